/* rtl/pcg_pkg.sv */
// ----------------------------------------------------------------------------
// pcg_pkg: shared types and constants
// Request codes, payload structs and fixed constants of the PCG32 block.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam logic [63:0] LcgMult = 64'd6364136223846793005;

  localparam logic [2:0] ReqDraw    = 3'd0;
  localparam logic [2:0] ReqBounded = 3'd1;
  localparam logic [2:0] ReqAdvance = 3'd2;
  localparam logic [2:0] ReqReseed  = 3'd3;
  localparam logic [2:0] ReqFrac    = 3'd4;

  localparam logic CfgSeed   = 1'b0;
  localparam logic CfgStream = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] bound;
    logic [63:0] draw_count;
  } req_t;

  typedef struct packed {
    logic [52:0] value;
    logic        bad_request;
  } rsp_t;

  // XSH-RR output function of an old state
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] x;
    x     = ((s >> 18) ^ s) >> 27;
    mixed = x[31:0];
    rot   = s[63:59];
    return (mixed >> rot) | (mixed << ((6'd32 - {1'b0, rot}) & 6'd31));
  endfunction

endpackage

/* rtl/pcg_mul.sv */
// ----------------------------------------------------------------------------
// pcg_mul: shared 64x64 low-half multiplier
// Three 32x32 partial products accumulated in turn, low 64 bits of the product.
// ----------------------------------------------------------------------------
module pcg_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [31:0] ma, mb;
  logic [63:0] pp;

  always_comb begin
    ma = a_q[31:0];
    mb = b_q[31:0];
    case (step_q)
      2'd1:    ma = a_q[63:32];
      2'd2:    mb = b_q[63:32];
      default: ;
    endcase
  end
  assign pp = ma * mb;

  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = '0;
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (step_q == 2'd0) acc_d = pp;
      else acc_d = acc_q + {pp[31:0], 32'd0};
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_o <= busy_q && (step_q == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign p_o = acc_q;
endmodule

/* rtl/pcg_div.sv */
// ----------------------------------------------------------------------------
// pcg_div: 32-bit restoring remainder unit
// One quotient bit per cycle; returns only the remainder.
// ----------------------------------------------------------------------------
module pcg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [31:0] num_q, den_q;
  logic [32:0] rem_q, sh;

  assign sh = {rem_q[31:0], num_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && (cnt_q == 6'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], 1'b0};
      if (sh >= {1'b0, den_q}) rem_q <= sh - {1'b0, den_q};
      else rem_q <= sh;
    end
  end

  assign rem_o = rem_q[31:0];
endmodule

/* rtl/pcg32_random_generator.sv */
// Plain draw: one draw, run on the shared multiplier.
// Fraction and reseed: two draws each.
// Bounded draw: two remainders per item on the bit-serial unit, one multiply per draw tried.
// Advance: 2 multiplies per clear count bit, 4 per set bit.
// One item at a time; a new item is taken once the result register is free.
// Reset: state 0, increment 1, seed and stream registers 0, no result pending.
module pcg32_random_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcg_pkg::req_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pcg_pkg::rsp_t     out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [63:0]       cfg_data_i
);
  import pcg_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SDrawM = 4'd1, SDrawW = 4'd2, SLim = 4'd3,
                         SMod = 4'd4, SJSq = 4'd5, SJAm = 4'd6, SJAi = 4'd7,
                         SJIm = 4'd8, SJFin = 4'd9, SOut = 4'd10, SLimW = 4'd11,
                         SModW = 4'd12, SJW = 4'd13;

  logic [3:0]  st_q;
  logic [63:0] state_q, inc_q, seed_q;
  logic [62:0] stream_q;
  logic [2:0]  kind_q;
  logic [31:0] bound_q, limit_q, draw_q;
  logic [63:0] cnt_q, jm_q, ji_q, am_q, ai_q, tmp_q;
  logic [1:0]  ndraw_q;
  logic [52:0] res_q;
  logic        bad_q, ovalid_q;

  logic        m_start, m_done, d_start, d_done;
  logic [63:0] m_a, m_b, m_p;
  logic [31:0] d_num, d_den, d_rem;
  logic [3:0]  jsub_q;

  pcg_mul u_mul (.clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
                 .done_o(m_done), .p_o(m_p));
  pcg_div u_div (.clk_i, .rst_ni, .start_i(d_start), .num_i(d_num), .den_i(d_den),
                 .done_o(d_done), .rem_o(d_rem));

  assign in_ready_o  = (st_q == SIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = '{value: res_q, bad_request: bad_q};

  always_comb begin
    m_start = 1'b0; m_a = state_q; m_b = LcgMult;
    d_start = 1'b0; d_num = 32'd0 - bound_q; d_den = bound_q;
    unique case (st_q)
      SDrawM: m_start = 1'b1;
      SLim:   d_start = 1'b1;
      SMod:   begin d_start = 1'b1; d_num = draw_q; end
      SJSq:   begin m_start = 1'b1; m_a = jm_q; m_b = jm_q; end
      SJAm:   begin m_start = 1'b1; m_a = am_q; m_b = jm_q; end
      SJAi:   begin m_start = 1'b1; m_a = ai_q; m_b = jm_q; end
      SJIm:   begin m_start = 1'b1; m_a = ji_q; m_b = jm_q + 64'd1; end
      SJFin:  begin m_start = 1'b1; m_a = am_q; m_b = state_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; state_q <= '0; inc_q <= 64'd1; seed_q <= '0; stream_q <= '0;
      ovalid_q <= 1'b0; res_q <= '0; bad_q <= 1'b0; jsub_q <= '0; ndraw_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSeed) seed_q <= cfg_data_i;
        else stream_q <= cfg_data_i[62:0];
      end
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        SIdle: if (in_valid_i && in_ready_o) begin
          kind_q <= in_data_i.req_type; bound_q <= in_data_i.bound;
          cnt_q <= in_data_i.draw_count; res_q <= '0; bad_q <= 1'b0;
          ndraw_q <= '0;
          unique case (in_data_i.req_type)
            ReqDraw, ReqFrac: st_q <= SDrawM;
            ReqBounded: if (in_data_i.bound == 32'd0) begin
                bad_q <= 1'b1; st_q <= SOut;
              end else st_q <= SLim;
            ReqAdvance: begin
              jm_q <= LcgMult; ji_q <= inc_q; am_q <= 64'd1; ai_q <= '0;
              st_q <= (in_data_i.draw_count == '0) ? SOut : SJSq;
              jsub_q <= '0;
            end
            ReqReseed: begin
              state_q <= '0; inc_q <= {stream_q, 1'b1}; st_q <= SDrawM;
            end
            default: st_q <= SOut;
          endcase
        end
        SDrawM: begin draw_q <= xsh_rr(state_q); st_q <= SDrawW; end
        SDrawW: if (m_done) begin
          state_q <= m_p + inc_q + ((kind_q == ReqReseed && ndraw_q == 2'd0) ? seed_q : '0);
          ndraw_q <= ndraw_q + 2'd1;
          unique case (kind_q)
            ReqDraw: begin res_q <= {21'd0, draw_q}; st_q <= SOut; end
            ReqBounded: st_q <= (draw_q < limit_q) ? SDrawM : SMod;
            ReqFrac: if (ndraw_q == 2'd0) begin
                res_q <= {draw_q[31:5], 26'd0}; st_q <= SDrawM;
              end else begin
                res_q <= res_q | {27'd0, draw_q[31:6]}; st_q <= SOut;
              end
            default: st_q <= (ndraw_q == 2'd0) ? SDrawM : SOut;
          endcase
        end
        SLim:  st_q <= SLimW;
        SLimW: if (d_done) begin limit_q <= d_rem; st_q <= SDrawM; end
        SMod:  st_q <= SModW;
        SModW: if (d_done) begin res_q <= {21'd0, d_rem}; st_q <= SOut; end
        // jump step: bit set -> acc_mul*=mul, acc_inc=acc_inc*mul+inc; then inc*=mul+1, mul*=mul
        SJSq, SJAm, SJAi, SJIm: begin jsub_q <= st_q; st_q <= SJW; end
        SJFin: begin jsub_q <= SJFin; st_q <= SJW; end
        SJW: if (m_done) begin
          unique case (jsub_q)
            SJSq: begin
              tmp_q <= m_p;
              st_q <= cnt_q[0] ? SJAm : SJIm;
            end
            SJAm: begin am_q <= m_p; st_q <= SJAi; end
            SJAi: begin ai_q <= m_p + ji_q; st_q <= SJIm; end
            SJIm: begin
              ji_q <= m_p; jm_q <= tmp_q; cnt_q <= cnt_q >> 1;
              st_q <= (cnt_q[63:1] == '0) ? SJFin : SJSq;
            end
            default: begin state_q <= m_p + ai_q; st_q <= SOut; end
          endcase
        end
        SOut: begin ovalid_q <= 1'b1; st_q <= SIdle; end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

/* rtl/pcg_checker.sv */
// ----------------------------------------------------------------------------
// pcg_checker: port-level checks
// Watches the top-level ports of the generator.
// ----------------------------------------------------------------------------
module pcg_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pcg_pkg::rsp_t out_data_o
);
  import pcg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while a result waits");
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result without work");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_request |-> out_data_o.value == '0)
    else $error("error result carries a value");
endmodule

bind pcg32_random_generator pcg_checker u_pcg_checker (.*);

/* tb/pcg32_random_generator_tb.sv */
// ----------------------------------------------------------------------------
// pcg32_random_generator_tb: self-checking bench for the PCG32 generator
// Drives draw, bounded, advance, reseed and fraction requests with random
// handshake gaps, predicts each result in a scoreboard and compares fields.
// ----------------------------------------------------------------------------
module pcg32_random_generator_tb;
  import pcg_pkg::*;

  localparam logic [63:0] Mask53 = 64'h001F_FFFF_FFFF_FFFF;

  // Golden generator state plus queue of expected responses
  class pcg_scoreboard;
    logic [63:0] lcg_state;
    logic [63:0] lcg_inc;
    logic [63:0] seed_reg;
    logic [62:0] stream_reg;
    rsp_t        rsp_q[$];
    int          mismatches;

    function new();
      lcg_state  = 64'd0;
      lcg_inc    = 64'd1;
      seed_reg   = 64'd0;
      stream_reg = 63'd0;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [63:0] data);
      if (idx == CfgSeed) seed_reg = data;
      else stream_reg = data[62:0];
    endfunction

    function logic [31:0] step_draw();
      logic [63:0] old;
      logic [31:0] mixed;
      logic [4:0]  rot;
      old       = lcg_state;
      lcg_state = old * LcgMult + lcg_inc;
      mixed     = 32'(((old >> 18) ^ old) >> 27);
      rot       = old[63:59];
      return (mixed >> rot) | (mixed << ((32 - rot) & 31));
    endfunction

    function void skip_ahead(logic [63:0] cnt);
      logic [63:0] mul, inc, amul, ainc;
      mul = LcgMult; inc = lcg_inc; amul = 64'd1; ainc = 64'd0;
      while (cnt != 0) begin
        if (cnt[0]) begin
          amul = amul * mul;
          ainc = ainc * mul + inc;
        end
        inc = inc * (mul + 64'd1);
        mul = mul * mul;
        cnt = cnt >> 1;
      end
      lcg_state = amul * lcg_state + ainc;
    endfunction

    function void note_request(req_t rq);
      rsp_t        r;
      logic [31:0] lim, v, hi, lo;
      r = '0;
      case (rq.req_type)
        ReqDraw: r.value = 53'(step_draw());
        ReqBounded: begin
          if (rq.bound == 0) r.bad_request = 1'b1;
          else begin
            lim = (32'd0 - rq.bound) % rq.bound;
            do v = step_draw(); while (v < lim);
            r.value = 53'(v % rq.bound);
          end
        end
        ReqAdvance: skip_ahead(rq.draw_count);
        ReqReseed: begin
          lcg_state = 64'd0;
          lcg_inc   = {stream_reg, 1'b1};
          void'(step_draw());
          lcg_state = lcg_state + seed_reg;
          void'(step_draw());
        end
        ReqFrac: begin
          hi = step_draw() >> 5;
          lo = step_draw() >> 6;
          r.value = 53'(((64'(hi) << 26) + 64'(lo)) & Mask53);
        end
        default: ;
      endcase
      rsp_q.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response value=%h", got.value);
        return;
      end
      want = rsp_q.pop_front();
      if (got.value !== want.value || got.bad_request !== want.bad_request) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp value=%h bad=%b, got value=%h bad=%b",
                   want.value, want.bad_request, got.value, got.bad_request);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [63:0] cfg_data_i = '0;

  pcg_scoreboard sb = new();
  bit            gaps_on = 1'b1;

  pcg32_random_generator dut (.*);

  always #5 clk_i = ~clk_i;

  // Response side: random stall bursts, then check on accept
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_response(out_data_o);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 14);
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Valid stays up between back-to-back items; it drops only for a gap or in wait_idle
  task automatic send_req(req_t rq);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(rq);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.rsp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly full-width bounds and jump counts, with occasional small values
  function automatic req_t rand_req();
    req_t rq;
    rq.draw_count = rand64();
    rq.bound      = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: rq.req_type = ReqDraw;
      3, 4:    rq.req_type = ReqBounded;
      5:       rq.req_type = ReqAdvance;
      6:       rq.req_type = ReqReseed;
      7, 8:    rq.req_type = ReqFrac;
      default: rq.req_type = 3'($urandom_range(5, 7));
    endcase
    if ($urandom_range(0, 3) == 0) rq.bound = $urandom_range(0, 20);
    if ($urandom_range(0, 3) == 0) rq.draw_count = 64'($urandom_range(0, 100));
    return rq;
  endfunction

  function automatic req_t mk(logic [2:0] kind, logic [31:0] bnd, logic [63:0] cnt);
    req_t rq;
    rq.req_type = kind; rq.bound = bnd; rq.draw_count = cnt;
    return rq;
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_req(mk(ReqDraw, 0, 0));
    send_req(mk(ReqFrac, 0, 0));
    send_req(mk(ReqBounded, 32'd0, 0));
    send_req(mk(ReqBounded, 32'd1, 0));
    send_req(mk(ReqBounded, 32'hFFFF_FFFF, 0));
    send_req(mk(ReqBounded, 32'h8000_0001, 0));
    send_req(mk(ReqBounded, 32'd3, 0));
    send_req(mk(ReqAdvance, 0, 64'd0));
    send_req(mk(ReqAdvance, 0, 64'd1));
    send_req(mk(ReqAdvance, 0, '1));
    send_req(mk(ReqReseed, 32'hFFFF_FFFF, '1));
    send_req(mk(3'd5, '1, '1));
    send_req(mk(3'd7, 0, 0));
    wait_idle();
    write_cfg(CfgSeed, '1);
    write_cfg(CfgStream, '1);
    send_req(mk(ReqReseed, 0, 0));
    send_req(mk(ReqDraw, 0, 0));
    send_req(mk(ReqAdvance, 0, 64'h8000_0000_0000_0000));
    send_req(mk(ReqFrac, 0, 0));
    wait_idle();
    write_cfg(CfgSeed, 64'd0);
    write_cfg(CfgStream, 64'd0);
    send_req(mk(ReqReseed, 0, 0));
    send_req(mk(ReqDraw, 0, 0));

    // random phases with fresh register settings
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_cfg(CfgSeed, rand64());
      write_cfg(CfgStream, rand64());
      if (ph == 7) gaps_on = 1'b0;
      for (int i = 0; i < 250; i++) send_req(rand_req());
    end
    wait_idle();
    repeat (100) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.rsp_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* pcg32_random_generator.f */
rtl/pcg_pkg.sv
rtl/pcg_mul.sv
rtl/pcg_div.sv
rtl/pcg32_random_generator.sv
rtl/pcg_checker.sv
tb/pcg32_random_generator_tb.sv
